// File: design/sct_pkg.sv
// Package for the 2-D segment crossing test: shared constants and the flag struct.
// No dependencies; every other file of the block but sct_det refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

    // Default coordinate width, two's complement
    localparam int CoordWidthDef = 16;

    // Fraction bits of each crossing parameter
    localparam int FracBits   = 16;
    localparam int ParamWidth = FracBits + 1;

    // Crossing parameter of exactly 1.0
    localparam logic [ParamWidth-1:0] ParamOne = {1'b1, {FracBits{1'b0}}};

    // Per-item status that rides along with the divider data
    typedef struct packed {
        logic par;  // denominator is zero
        logic ok1;  // first parameter lies in [0,1]
        logic ok2;  // second parameter lies in [0,1]
        logic eq1;  // first parameter is exactly 1.0
        logic eq2;  // second parameter is exactly 1.0
    } t_flags;

endpackage

`default_nettype wire

// File: design/sct_if.sv
// Valid/ready channel interfaces for the segment crossing test.
// Depends on sct_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface sct_in_if #(
    parameter int COORD_WIDTH = sct_pkg::CoordWidthDef
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_start_x;
    logic signed [COORD_WIDTH-1:0] first_start_z;
    logic signed [COORD_WIDTH-1:0] first_end_x;
    logic signed [COORD_WIDTH-1:0] first_end_z;
    logic signed [COORD_WIDTH-1:0] second_start_x;
    logic signed [COORD_WIDTH-1:0] second_start_z;
    logic signed [COORD_WIDTH-1:0] second_end_x;
    logic signed [COORD_WIDTH-1:0] second_end_z;

    modport source (
        output valid, first_start_x, first_start_z, first_end_x, first_end_z,
               second_start_x, second_start_z, second_end_x, second_end_z,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_z, first_end_x, first_end_z,
               second_start_x, second_start_z, second_end_x, second_end_z,
        output ready
    );
endinterface

interface sct_out_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic                            parallel;
    logic [sct_pkg::ParamWidth-1:0]  first_param;
    logic [sct_pkg::ParamWidth-1:0]  second_param;

    modport source (
        output valid, hit, parallel, first_param, second_param,
        input  ready
    );
    modport sink (
        input  valid, hit, parallel, first_param, second_param,
        output ready
    );
endinterface

`default_nettype wire

// File: design/segment_crossing_test_2d_top.sv
// Pipeline: 3 determinant stages, 1 normalization stage, 16 divider stages and
//   1 output register between an input transfer and its result on the output channel.
// Throughput: one segment pair per cycle unless the output stalls; every stage
//   advances together and the 16-stage restoring divider pair sets the depth.
// Reset: synchronous, active low; clears all valid bits and the input skid entry.
// Top level of the 2-D segment crossing test; depends on sct_pkg, sct_if, sct_det,
// sct_norm and sct_div.
`timescale 1ns / 1ps
`default_nettype none

module segment_crossing_test_2d_top #(
    parameter int COORD_WIDTH = sct_pkg::CoordWidthDef
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sct_in_if.sink     i_in,
    sct_out_if.source  o_out
);

    localparam int DetW = 2 * COORD_WIDTH + 3;
    localparam int FB   = sct_pkg::FracBits;
    localparam int PW   = sct_pkg::ParamWidth;

    // ------------------------------------------------------------------
    // Global advance: the pipeline moves whenever the output register is
    // empty or its result is being taken this cycle.
    // ------------------------------------------------------------------
    logic r_out_v;
    logic s_en;
    assign s_en = !r_out_v || o_out.ready;

    // ------------------------------------------------------------------
    // Input skid entry: ready comes from a register, so the input side
    // never waits on the output ready path. A transfer that arrives
    // during a stall is parked here and fed in first once the pipe moves.
    // ------------------------------------------------------------------
    logic                          r_sk_v;
    logic signed [COORD_WIDTH-1:0] r_sk_ax, r_sk_az, r_sk_bx, r_sk_bz;
    logic signed [COORD_WIDTH-1:0] r_sk_mx, r_sk_mz, r_sk_nx, r_sk_nz;
    logic                          s_in_xfer;
    logic                          s_feed_v;

    assign i_in.ready = !r_sk_v;
    assign s_in_xfer  = i_in.valid && !r_sk_v;
    assign s_feed_v   = r_sk_v || i_in.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (s_en) begin
            // drain the parked item into the pipe
            r_sk_v <= 1'b0;
        end else if (s_in_xfer) begin
            // hold the new transfer while the pipe is stalled
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s_en && s_in_xfer) begin
            r_sk_ax <= i_in.first_start_x;
            r_sk_az <= i_in.first_start_z;
            r_sk_bx <= i_in.first_end_x;
            r_sk_bz <= i_in.first_end_z;
            r_sk_mx <= i_in.second_start_x;
            r_sk_mz <= i_in.second_start_z;
            r_sk_nx <= i_in.second_end_x;
            r_sk_nz <= i_in.second_end_z;
        end
    end

    // skid entry has priority; a live input is only taken when it is empty
    logic signed [COORD_WIDTH-1:0] s_ax, s_az, s_bx, s_bz, s_mx, s_mz, s_nx, s_nz;
    assign s_ax = r_sk_v ? r_sk_ax : i_in.first_start_x;
    assign s_az = r_sk_v ? r_sk_az : i_in.first_start_z;
    assign s_bx = r_sk_v ? r_sk_bx : i_in.first_end_x;
    assign s_bz = r_sk_v ? r_sk_bz : i_in.first_end_z;
    assign s_mx = r_sk_v ? r_sk_mx : i_in.second_start_x;
    assign s_mz = r_sk_v ? r_sk_mz : i_in.second_start_z;
    assign s_nx = r_sk_v ? r_sk_nx : i_in.second_end_x;
    assign s_nz = r_sk_v ? r_sk_nz : i_in.second_end_z;

    // ------------------------------------------------------------------
    // Determinants R, X and S (three stages)
    // ------------------------------------------------------------------
    logic                   s_det_v;
    logic signed [DetW-1:0] s_r, s_x, s_s;

    sct_det #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (s_feed_v),
        .i_ax    (s_ax),
        .i_az    (s_az),
        .i_bx    (s_bx),
        .i_bz    (s_bz),
        .i_mx    (s_mx),
        .i_mz    (s_mz),
        .i_nx    (s_nx),
        .i_nz    (s_nz),
        .o_valid (s_det_v),
        .o_r     (s_r),
        .o_x     (s_x),
        .o_s     (s_s)
    );

    // ------------------------------------------------------------------
    // Sign normalization and range checks (one stage)
    // ------------------------------------------------------------------
    logic              s_nrm_v;
    logic [DetW-1:0]   s_n1, s_n2, s_d;
    sct_pkg::t_flags   s_nrm_flags;

    sct_norm #(
        .DET_WIDTH(DetW)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (s_det_v),
        .i_r     (s_r),
        .i_x     (s_x),
        .i_s     (s_s),
        .o_valid (s_nrm_v),
        .o_n1    (s_n1),
        .o_n2    (s_n2),
        .o_d     (s_d),
        .o_flags (s_nrm_flags)
    );

    // ------------------------------------------------------------------
    // Fraction bits of both parameters (sixteen stages)
    // ------------------------------------------------------------------
    logic              s_div_v;
    logic [FB-1:0]     s_q1, s_q2;
    sct_pkg::t_flags   s_div_flags;

    sct_div #(
        .DET_WIDTH(DetW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (s_nrm_v),
        .i_n1    (s_n1),
        .i_n2    (s_n2),
        .i_d     (s_d),
        .i_flags (s_nrm_flags),
        .o_valid (s_div_v),
        .o_q1    (s_q1),
        .o_q2    (s_q2),
        .o_flags (s_div_flags)
    );

    // ------------------------------------------------------------------
    // Result assembly and output register. A parallel pair or any
    // parameter outside [0,1] drops the hit and zeroes both fractions;
    // an exact 1.0 replaces the quotient bits.
    // ------------------------------------------------------------------
    logic          s_hit;
    logic [PW-1:0] n_p1, n_p2;
    logic          r_hit, r_par;
    logic [PW-1:0] r_p1, r_p2;

    always_comb begin
        s_hit = !s_div_flags.par && s_div_flags.ok1 && s_div_flags.ok2;
        n_p1  = '0;
        n_p2  = '0;
        if (s_hit) begin
            n_p1 = s_div_flags.eq1 ? sct_pkg::ParamOne : {1'b0, s_q1};
            n_p2 = s_div_flags.eq2 ? sct_pkg::ParamOne : {1'b0, s_q2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s_en) begin
            r_out_v <= s_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_hit <= s_hit;
            r_par <= s_div_flags.par;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.hit          = r_hit;
    assign o_out.parallel     = r_par;
    assign o_out.first_param  = r_p1;
    assign o_out.second_param = r_p2;

endmodule

`default_nettype wire

// File: design/sct_det.sv
// Determinant pipeline: edge vectors, six cross products, then R, X and S.
// Three register stages; depends on nothing but its parameter.
`timescale 1ns / 1ps
`default_nettype none

module sct_det #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic signed [COORD_WIDTH-1:0]   i_ax,
    input  wire logic signed [COORD_WIDTH-1:0]   i_az,
    input  wire logic signed [COORD_WIDTH-1:0]   i_bx,
    input  wire logic signed [COORD_WIDTH-1:0]   i_bz,
    input  wire logic signed [COORD_WIDTH-1:0]   i_mx,
    input  wire logic signed [COORD_WIDTH-1:0]   i_mz,
    input  wire logic signed [COORD_WIDTH-1:0]   i_nx,
    input  wire logic signed [COORD_WIDTH-1:0]   i_nz,
    output logic                                 o_valid,
    output logic signed [2*COORD_WIDTH+2:0]      o_r,
    output logic signed [2*COORD_WIDTH+2:0]      o_x,
    output logic signed [2*COORD_WIDTH+2:0]      o_s
);

    localparam int DiffW = COORD_WIDTH + 1;
    localparam int ProdW = 2 * DiffW;
    localparam int DetW  = ProdW + 1;

    logic [2:0] r_v;

    // stage 1: edge vectors
    logic signed [DiffW-1:0] r_cx, r_cz, r_px, r_pz, r_hx, r_hz;
    // stage 2: products
    logic signed [ProdW-1:0] r_hzpx, r_hxpz, r_czhx, r_cxhz, r_czpx, r_cxpz;
    // stage 3: determinants
    logic signed [DetW-1:0]  r_r, r_x, r_s;

    function automatic logic signed [DiffW-1:0] sub_ext(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        sub_ext = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    endfunction

    function automatic logic signed [DetW-1:0] sub_prod(
        input logic signed [ProdW-1:0] a,
        input logic signed [ProdW-1:0] b
    );
        sub_prod = {a[ProdW-1], a} - {b[ProdW-1], b};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx <= sub_ext(i_bx, i_ax);
            r_cz <= sub_ext(i_bz, i_az);
            r_px <= sub_ext(i_mx, i_nx);
            r_pz <= sub_ext(i_mz, i_nz);
            r_hx <= sub_ext(i_ax, i_mx);
            r_hz <= sub_ext(i_az, i_mz);

            r_hzpx <= ProdW'(r_hz * r_px);
            r_hxpz <= ProdW'(r_hx * r_pz);
            r_czhx <= ProdW'(r_cz * r_hx);
            r_cxhz <= ProdW'(r_cx * r_hz);
            r_czpx <= ProdW'(r_cz * r_px);
            r_cxpz <= ProdW'(r_cx * r_pz);

            r_r <= sub_prod(r_hzpx, r_hxpz);
            r_x <= sub_prod(r_czhx, r_cxhz);
            r_s <= sub_prod(r_czpx, r_cxpz);
        end
    end

    assign o_valid = r_v[2];
    assign o_r     = r_r;
    assign o_x     = r_x;
    assign o_s     = r_s;

endmodule

`default_nettype wire

// File: design/sct_norm.sv
// Sign normalization: makes the denominator non-negative and range-checks both numerators.
// One register stage; depends on sct_pkg for the flag struct.
`timescale 1ns / 1ps
`default_nettype none

module sct_norm #(
    parameter int DET_WIDTH = 35
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic signed [DET_WIDTH-1:0]   i_r,
    input  wire logic signed [DET_WIDTH-1:0]   i_x,
    input  wire logic signed [DET_WIDTH-1:0]   i_s,
    output logic                               o_valid,
    output logic [DET_WIDTH-1:0]               o_n1,
    output logic [DET_WIDTH-1:0]               o_n2,
    output logic [DET_WIDTH-1:0]               o_d,
    output sct_pkg::t_flags                    o_flags
);

    logic                        r_v;
    logic [DET_WIDTH-1:0]        r_n1, r_n2, r_d;
    sct_pkg::t_flags             r_flags;

    logic                        s_neg;
    logic signed [DET_WIDTH-1:0] n_n1, n_n2;
    logic [DET_WIDTH-1:0]        n_d;
    sct_pkg::t_flags             n_flags;

    // t = -R/S, s = -X/S; flip all signs when S is negative
    always_comb begin
        s_neg = i_s[DET_WIDTH-1];
        n_n1  = s_neg ? i_r : -i_r;
        n_n2  = s_neg ? i_x : -i_x;
        n_d   = s_neg ? DET_WIDTH'(-i_s) : DET_WIDTH'(i_s);
        n_flags.par = (i_s == '0);
        n_flags.ok1 = !n_n1[DET_WIDTH-1] && ($unsigned(n_n1) <= n_d);
        n_flags.ok2 = !n_n2[DET_WIDTH-1] && ($unsigned(n_n2) <= n_d);
        n_flags.eq1 = ($unsigned(n_n1) == n_d);
        n_flags.eq2 = ($unsigned(n_n2) == n_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n1    <= $unsigned(n_n1);
            r_n2    <= $unsigned(n_n2);
            r_d     <= n_d;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_v;
    assign o_n1    = r_n1;
    assign o_n2    = r_n2;
    assign o_d     = r_d;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

// File: design/sct_div.sv
// Pipelined restoring divider pair: one quotient bit of each parameter per stage.
// Depends on sct_pkg for the fraction width and the flag struct.
`timescale 1ns / 1ps
`default_nettype none

module sct_div #(
    parameter int DET_WIDTH = 35
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [DET_WIDTH-1:0]              i_n1,
    input  wire logic [DET_WIDTH-1:0]              i_n2,
    input  wire logic [DET_WIDTH-1:0]              i_d,
    input  wire sct_pkg::t_flags                   i_flags,
    output logic                                   o_valid,
    output logic [sct_pkg::FracBits-1:0]           o_q1,
    output logic [sct_pkg::FracBits-1:0]           o_q2,
    output sct_pkg::t_flags                        o_flags
);

    localparam int Steps = sct_pkg::FracBits;

    logic [Steps-1:0]         r_v;
    logic [DET_WIDTH-1:0]     r_rem1 [Steps];
    logic [DET_WIDTH-1:0]     r_rem2 [Steps];
    logic [DET_WIDTH-1:0]     r_d    [Steps];
    logic [Steps-1:0]         r_q1   [Steps];
    logic [Steps-1:0]         r_q2   [Steps];
    sct_pkg::t_flags          r_flags[Steps];

    logic [DET_WIDTH-1:0]     n_rem1 [Steps];
    logic [DET_WIDTH-1:0]     n_rem2 [Steps];
    logic [Steps-1:0]         n_q1   [Steps];
    logic [Steps-1:0]         n_q2   [Steps];

    // remainder stays below d, so the doubled value fits the same width
    always_comb begin
        logic [DET_WIDTH-1:0] rem1, rem2, d;
        logic [Steps-1:0]     q1, q2;
        for (int k = 0; k < Steps; k++) begin
            if (k == 0) begin
                rem1 = i_n1;
                rem2 = i_n2;
                d    = i_d;
                q1   = '0;
                q2   = '0;
            end else begin
                rem1 = r_rem1[k-1];
                rem2 = r_rem2[k-1];
                d    = r_d[k-1];
                q1   = r_q1[k-1];
                q2   = r_q2[k-1];
            end
            rem1 = {rem1[DET_WIDTH-2:0], 1'b0};
            rem2 = {rem2[DET_WIDTH-2:0], 1'b0};
            if (rem1 >= d) begin
                n_rem1[k] = rem1 - d;
                n_q1[k]   = {q1[Steps-2:0], 1'b1};
            end else begin
                n_rem1[k] = rem1;
                n_q1[k]   = {q1[Steps-2:0], 1'b0};
            end
            if (rem2 >= d) begin
                n_rem2[k] = rem2 - d;
                n_q2[k]   = {q2[Steps-2:0], 1'b1};
            end else begin
                n_rem2[k] = rem2;
                n_q2[k]   = {q2[Steps-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Steps-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Steps; k++) begin
                r_rem1[k]  <= n_rem1[k];
                r_rem2[k]  <= n_rem2[k];
                r_q1[k]    <= n_q1[k];
                r_q2[k]    <= n_q2[k];
                r_d[k]     <= (k == 0) ? i_d : r_d[k-1];
                r_flags[k] <= (k == 0) ? i_flags : r_flags[k-1];
            end
        end
    end

    assign o_valid = r_v[Steps-1];
    assign o_q1    = r_q1[Steps-1];
    assign o_q2    = r_q2[Steps-1];
    assign o_flags = r_flags[Steps-1];

endmodule

`default_nettype wire
